/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/lspe_pkg.sv */
// Shared types, constants and the sensor weight table of the position estimator.
`timescale 1ns / 1ps

package lspe_pkg;

    // Fixed field widths
    localparam int WORD_W  = 16;   // raw sensor word
    localparam int POS_W   = 14;   // signed position
    localparam int CNT_W   = 4;    // lit and selected counters
    localparam int SUM_W   = 9;    // signed weight sum, |sum| <= 157
    localparam int MAG_W   = 8;    // magnitude of the weight sum
    localparam int WT_W    = 6;    // one signed weight
    localparam int IDX_W   = 5;    // sensor index, up to 31
    localparam int MODE_W  = 2;

    // Highest sensor that exists in the word and the table
    localparam int LAST_SENSOR = 15;

    // Saturation limits of the position
    localparam int POS_MAX     = 8191;
    localparam int POS_MIN_MAG = 8192;

    // Scan mode codes
    localparam logic [MODE_W-1:0] MODE_ALL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture sensor word, clear accumulators
        logic scan;       // evaluate one sensor
        logic div_load;   // set up the divider
        logic div_step;   // one quotient bit
        logic out_load;   // write the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_last;  // current sensor is the last in scan order
        logic sel_zero;   // nothing selected
        logic div_last;   // final quotient bit in this step
    } t_status;

    // Weight of sensor k; zero outside 1..15
    function automatic logic signed [WT_W-1:0] weight(input logic [IDX_W-1:0] k);
        logic signed [WT_W-1:0] w;
        unique case (k)
            5'd1:    w = 6'sd30;
            5'd2:    w = 6'sd27;
            5'd3:    w = 6'sd25;
            5'd4:    w = 6'sd23;
            5'd5:    w = 6'sd20;
            5'd6:    w = 6'sd17;
            5'd7:    w = 6'sd15;
            5'd8:    w = 6'sd0;
            5'd9:    w = -6'sd15;
            5'd10:   w = -6'sd17;
            5'd11:   w = -6'sd20;
            5'd12:   w = -6'sd23;
            5'd13:   w = -6'sd25;
            5'd14:   w = -6'sd27;
            5'd15:   w = -6'sd30;
            default: w = 6'sd0;
        endcase
        return w;
    endfunction

endpackage

/* sv/lspe_ctrl.sv */
// Controller state machine: sequences load, sensor scan, division and output.
`timescale 1ns / 1ps

module lspe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lspe_pkg::t_status i_status,
    output lspe_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.div_load = 1'b1;
                n_state        = i_status.sel_zero ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid: set on load, cleared on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* sv/lspe_dp.sv */
// Datapath: sensor scan with run selection, serial divider, output register.
`timescale 1ns / 1ps

module lspe_dp #(
    parameter int SENSOR_COUNT  = 15,
    parameter int MAX_RUN       = 3,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  lspe_pkg::t_cmd                           i_cmd,
    output lspe_pkg::t_status                        o_status,
    input  logic [lspe_pkg::WORD_W-1:0]              i_sensor_bits,
    input  logic                                     i_cfg_wr_en,
    input  logic [lspe_pkg::MODE_W-1:0]              i_cfg_wr_data,
    output logic signed [lspe_pkg::POS_W-1:0]        o_line_position,
    output logic [lspe_pkg::CNT_W-1:0]               o_lit_count,
    output logic                                     o_held
);

    localparam int SW   = $clog2(SENSOR_COUNT + 1);
    localparam int SW1  = SW + 1;
    localparam int CW   = lspe_pkg::CNT_W;
    localparam int SUMW = lspe_pkg::SUM_W;
    localparam int IW   = lspe_pkg::IDX_W;
    localparam int PW   = lspe_pkg::POS_W;
    localparam int NW   = lspe_pkg::MAG_W + FRACTION_BITS;
    localparam int EW   = (NW > PW) ? NW : PW;
    localparam int DCW  = $clog2(NW + 1);

    localparam logic [SW-1:0] K_FIRST = SW'(1);
    localparam logic [SW-1:0] K_LAST  = SW'(SENSOR_COUNT);
    localparam logic [CW-1:0] RUN_LIM = CW'(MAX_RUN);

    // Configuration and captured item
    logic [lspe_pkg::MODE_W-1:0] r_mode;
    logic [lspe_pkg::WORD_W-1:0] r_word;
    logic                        r_run;
    logic                        r_down;

    // Scan state
    logic [SW-1:0]          r_k;
    logic [SW-1:0]          r_prev;
    logic [CW-1:0]          r_lit;
    logic [CW-1:0]          r_sel;
    logic signed [SUMW-1:0] r_sum;
    logic                   r_closed;

    logic [SW-1:0]          n_prev;
    logic [CW-1:0]          n_lit;
    logic [CW-1:0]          n_sel;
    logic signed [SUMW-1:0] n_sum;
    logic                   n_closed;

    // Divider state
    logic [NW-1:0]  r_num;
    logic [CW-1:0]  r_rem;
    logic [DCW-1:0] r_cnt;
    logic           r_neg;

    // Held position
    logic signed [PW-1:0] r_last_pos;

    logic [IW-1:0]                    k5;
    logic                             lit_k;
    logic signed [lspe_pkg::WT_W-1:0] w_k;
    logic                             adjacent;
    logic [SW1-1:0]                   k_ext;
    logic [SW1-1:0]                   prev_ext;

    logic signed [SUMW-1:0] sum_abs;
    logic [CW:0]            rem_sh;
    logic [CW:0]            rem_diff;
    logic                   q_bit;

    logic [EW-1:0]        q_ext;
    logic [EW-1:0]        q_lim;
    logic [EW-1:0]        q_sat;
    logic [PW-1:0]        mag;
    logic signed [PW-1:0] pos_calc;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lspe_pkg::MODE_ALL;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // Current sensor: lit bit and weight
    assign k5    = IW'(r_k);
    assign lit_k = (k5 <= IW'(lspe_pkg::LAST_SENSOR)) && r_word[k5[3:0]];
    assign w_k   = lspe_pkg::weight(k5);

    assign k_ext    = SW1'(r_k);
    assign prev_ext = SW1'(r_prev);
    assign adjacent = (k_ext == prev_ext + SW1'(1)) || (prev_ext == k_ext + SW1'(1));

    // One scan step: counting, averaging or run selection
    always_comb begin
        n_prev   = r_prev;
        n_lit    = r_lit;
        n_sel    = r_sel;
        n_sum    = r_sum;
        n_closed = r_closed;
        if (lit_k) begin
            n_lit = r_lit + CW'(1);
            if (!r_run) begin
                n_sum = r_sum + SUMW'(w_k);
                n_sel = r_sel + CW'(1);
            end else if (!r_closed && (r_sel < RUN_LIM)) begin
                priority if (r_sel == '0) begin
                    n_sum = SUMW'(w_k);
                    n_sel = CW'(1);
                end else if (adjacent) begin
                    n_sum = r_sum + SUMW'(w_k);
                    n_sel = r_sel + CW'(1);
                end else if (r_sel == CW'(1)) begin
                    // lone member broken off: start over
                    n_sum = '0;
                    n_sel = '0;
                end else begin
                    n_closed = 1'b1;
                end
                n_prev = r_k;
            end
        end
    end

    // Restoring divide step, one quotient bit
    assign sum_abs  = r_sum[SUMW-1] ? -r_sum : r_sum;
    assign rem_sh   = {r_rem, r_num[NW-1]};
    assign rem_diff = rem_sh - (CW+1)'(r_sel);
    assign q_bit    = (rem_sh >= (CW+1)'(r_sel));

    // Saturate and apply sign
    assign q_ext    = EW'(r_num);
    assign q_lim    = r_neg ? EW'(lspe_pkg::POS_MIN_MAG) : EW'(lspe_pkg::POS_MAX);
    assign q_sat    = (q_ext > q_lim) ? q_lim : q_ext;
    assign mag      = q_sat[PW-1:0];
    assign pos_calc = r_neg ? $signed(PW'(0) - mag) : $signed(mag);

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word   <= i_sensor_bits;
            r_run    <= (r_mode == lspe_pkg::MODE_UP) || (r_mode == lspe_pkg::MODE_DOWN);
            r_down   <= (r_mode == lspe_pkg::MODE_DOWN);
            r_k      <= (r_mode == lspe_pkg::MODE_DOWN) ? K_LAST : K_FIRST;
            r_prev   <= '0;
            r_lit    <= '0;
            r_sel    <= '0;
            r_sum    <= '0;
            r_closed <= 1'b0;
        end else if (i_cmd.scan) begin
            r_k      <= r_down ? (r_k - SW'(1)) : (r_k + SW'(1));
            r_prev   <= n_prev;
            r_lit    <= n_lit;
            r_sel    <= n_sel;
            r_sum    <= n_sum;
            r_closed <= n_closed;
        end
        if (i_cmd.div_load) begin
            r_num <= NW'(sum_abs[lspe_pkg::MAG_W-1:0]) << FRACTION_BITS;
            r_rem <= '0;
            r_cnt <= '0;
            r_neg <= r_sum[SUMW-1];
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NW-2:0], q_bit};
            r_rem <= q_bit ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
            r_cnt <= r_cnt + DCW'(1);
        end
        if (i_cmd.out_load) begin
            o_line_position <= (r_sel == '0) ? r_last_pos : pos_calc;
            o_lit_count     <= r_lit;
            o_held          <= (r_sel == '0);
        end
    end

    // Last position, kept across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos <= '0;
        end else if (i_cmd.out_load && (r_sel != '0)) begin
            r_last_pos <= pos_calc;
        end
    end

    assign o_status.scan_last = r_down ? (r_k == K_FIRST) : (r_k == K_LAST);
    assign o_status.sel_zero  = (r_sel == '0);
    assign o_status.div_last  = (r_cnt == DCW'(NW - 1));

endmodule

/* sv/line_sensor_position_estimator.sv */
// Sequence from input transfer to output valid: load, a scan of every sensor, divider setup,
// one divide step per quotient bit, then the output load, which waits until the output
// register is free; the divide steps are skipped when nothing is selected.
// A new item is taken only while the block is idle, which may be while the last result
// still waits in the output register.
// Reset: synchronous, active low; clears mode to average-all, last position to zero.
`timescale 1ns / 1ps

module line_sensor_position_estimator #(
    parameter int SENSOR_COUNT  = 15,
    parameter int MAX_RUN       = 3,
    parameter int FRACTION_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lspe_pkg::WORD_W-1:0]       i_sensor_bits,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [lspe_pkg::POS_W-1:0] o_line_position,
    output logic [lspe_pkg::CNT_W-1:0]        o_lit_count,
    output logic                              o_held,
    input  logic                              i_cfg_wr_en,
    input  logic [lspe_pkg::MODE_W-1:0]       i_cfg_wr_data
);

    lspe_pkg::t_cmd    cmd;
    lspe_pkg::t_status status;

    // Sequencer
    lspe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Scan, divide and output registers
    lspe_dp #(
        .SENSOR_COUNT  (SENSOR_COUNT),
        .MAX_RUN       (MAX_RUN),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_sensor_bits   (i_sensor_bits),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_line_position (o_line_position),
        .o_lit_count     (o_lit_count),
        .o_held          (o_held)
    );

endmodule

/* sv/lspe_checker.sv */
// Port-level checker for the position estimator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lspe_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [lspe_pkg::POS_W-1:0] i_line_position,
    input logic [lspe_pkg::CNT_W-1:0]        i_lit_count,
    input logic                              i_held
);

    logic signed [lspe_pkg::POS_W-1:0] r_last_seen;
    logic signed [lspe_pkg::POS_W-1:0] r_prev_pos;
    logic [lspe_pkg::CNT_W-1:0]        r_prev_lit;
    logic                              r_prev_held;
    logic                              out_xfer;
    logic                              in_xfer;
    logic                              held_out;
    logic                              fresh_out;
    logic                              out_stall;
    logic                              out_same;

    assign out_xfer  = i_out_valid && i_out_ready;
    assign in_xfer   = i_in_valid && i_in_ready;
    assign held_out  = i_out_valid && i_held;
    assign fresh_out = i_out_valid && !i_held;
    assign out_stall = i_out_valid && !i_out_ready;
    assign out_same  = (i_line_position == r_prev_pos) && (i_lit_count == r_prev_lit)
                       && (i_held == r_prev_held);

    // Last position delivered on the output channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seen <= '0;
        end else if (out_xfer) begin
            r_last_seen <= i_line_position;
        end
    end

    // Output fields as seen at the previous edge
    always_ff @(posedge i_clk) begin
        r_prev_pos  <= i_line_position;
        r_prev_lit  <= i_lit_count;
        r_prev_held <= i_held;
    end

    // A held result repeats the last delivered position
    `ASSERT_IMPL(a_held_repeats, i_clk, i_rst_n, held_out, i_line_position == r_last_seen)

    // A fresh position needs at least one lit sensor
    `ASSERT_IMPL(a_fresh_has_lit, i_clk, i_rst_n, fresh_out, i_lit_count != '0)

    // The block is busy right after taking an item
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_xfer, !i_in_ready)

    // A stalled result stays put
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && out_same)

endmodule

bind line_sensor_position_estimator lspe_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .i_in_ready      (o_in_ready),
    .i_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .i_line_position (o_line_position),
    .i_lit_count     (o_lit_count),
    .i_held          (o_held)
);
